### src/sbld_pkg.sv
// Package for the sine breathing LED dimmer: register map, reset values,
// data widths and the constant function that builds the quarter-wave sine table.
// Depends on nothing; imported by sine_breathing_led_dimmer.
package sbld_pkg;

  localparam int ANGLE_BITS_DEF     = 10;
  localparam int SINE_FRAC_BITS_DEF = 15;

  localparam int NOW_W    = 32;
  localparam int CHAN_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int U_W      = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;

  localparam logic [CHAN_W-1:0]   RST_BASE_RED   = 8'd0;
  localparam logic [CHAN_W-1:0]   RST_BASE_GREEN = 8'd20;
  localparam logic [CHAN_W-1:0]   RST_BASE_BLUE  = 8'd80;
  localparam logic [CHAN_W-1:0]   RST_FLOOR      = 8'd10;
  localparam logic [CHAN_W-1:0]   RST_CEILING    = 8'd200;
  localparam logic [PERIOD_W-1:0] RST_PERIOD     = 16'd4000;
  localparam logic [PERIOD_W-1:0] RST_INTERVAL   = 16'd20;

  typedef enum logic [2:0] {
    REG_BASE_RED   = 3'd0,
    REG_BASE_GREEN = 3'd1,
    REG_BASE_BLUE  = 3'd2,
    REG_FLOOR      = 3'd3,
    REG_CEILING    = 3'd4,
    REG_PERIOD     = 3'd5,
    REG_INTERVAL   = 3'd6
  } reg_idx_t;

  // pi in Q2.30 and one in Q30
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  // Divisors (2n)(2n+1) of the Taylor series terms, n = 1..10.
  localparam int TAYLOR_TERMS = 10;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // Magnitude of sin for r quarter steps, rounded to f fraction bits.
  // Only evaluated at elaboration to fill the constant table.
  function automatic longint unsigned quarter_sine(longint unsigned r, int ab, int f);
    longint unsigned x;
    longint unsigned term;
    longint unsigned s;
    longint unsigned top;
    longint          sum;
    x    = (PI_Q30 * r) >> (ab - 1);
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0)       sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    s   = (longint'(sum) + (64'd1 << (29 - f))) >> (30 - f);
    top = (64'd1 << f) - 64'd1;
    if (s > top) s = top;
    return s;
  endfunction

endpackage

### src/sine_breathing_led_dimmer.sv
// Top level of the sine breathing LED dimmer: APB register bank, bit-serial
// divider for phase and angle, quarter-wave sine table and colour scaling.
// Depends on sbld_pkg.

// The block takes millisecond time stamps on the in_ stream and, when at
// least interval_ms milliseconds (unsigned, wrapping) have passed since the
// last update, produces one transfer on the out_ stream holding the scaled
// red, green and blue channels and the brightness level used. A time stamp
// that comes too early produces nothing and is absorbed.
// An update occupies the block from its transfer to the earliest next input
// transfer: a restoring divider that retires one bit per cycle first forms
// now_ms mod period_ms and then the angle index, followed by a table read,
// the half-lift, the brightness multiply, the three channels in turn on one
// shared channel multiplier and an idle state in which the result moves to
// the output register while the next time stamp may already be taken. The
// output register lets a finished result wait for the downstream side while
// the next time stamp is being worked on; when a second result is finished
// before the first has left, in_tready stays low until the output register
// frees up. A period of zero acts as one, and a ceiling below the floor acts
// as the floor.
// Registers sit at byte address 4*i in the order base_red, base_green,
// base_blue, bright_floor, bright_ceiling, period_ms, interval_ms; writes
// should be issued only while the block is idle.
module sine_breathing_led_dimmer #(
  parameter int ANGLE_BITS     = sbld_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = sbld_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream; tdata: now_ms[31:0]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sbld_pkg::NOW_W-1:0]    in_tdata,
  // Result stream; tdata: red[7:0], green[15:8], blue[23:16], level[31:24]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*sbld_pkg::CHAN_W-1:0] out_tdata,
  // Configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sbld_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [sbld_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [sbld_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import sbld_pkg::*;

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int IDX_W   = ANGLE_BITS - 1;
  localparam int LIFT_W  = SINE_FRAC_BITS + 1;
  localparam int CNT_W   = $clog2((NOW_W > ANGLE_BITS) ? NOW_W : ANGLE_BITS);
  localparam int PROD_W  = U_W + CHAN_W;
  localparam int CPROD_W = 2 * CHAN_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_ANG   = 7'b0000100,
    S_LUT   = 7'b0001000,
    S_LIFT  = 7'b0010000,
    S_LEVEL = 7'b0100000,
    S_CHAN  = 7'b1000000
  } state_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Configuration registers
  logic [CHAN_W-1:0]   base_red_r, base_green_r, base_blue_r;
  logic [CHAN_W-1:0]   floor_r, ceiling_r;
  logic [PERIOD_W-1:0] period_r, interval_r;

  // Control and datapath registers
  state_t              state_r, state_nxt;
  logic [NOW_W-1:0]    last_r;
  logic [NOW_W-1:0]    dvd_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [ANGLE_BITS-1:0] quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SINE_FRAC_BITS-1:0] mag_r;
  logic                neg_r;
  logic [U_W-1:0]      u_r;
  logic [CHAN_W-1:0]   level_r;
  logic [1:0]          ch_r;
  logic [CHAN_W-1:0]   red_r, green_r, blue_r;
  logic                pend_r;
  logic                out_valid_r;
  logic [4*CHAN_W-1:0] out_data_r;

  // ---------------------------------------------------------------------
  // Register bank. pready is tied high, so every access completes in the
  // cycle after setup.
  // ---------------------------------------------------------------------
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_red_r   <= RST_BASE_RED;
      base_green_r <= RST_BASE_GREEN;
      base_blue_r  <= RST_BASE_BLUE;
      floor_r      <= RST_FLOOR;
      ceiling_r    <= RST_CEILING;
      period_r     <= RST_PERIOD;
      interval_r   <= RST_INTERVAL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE_RED:   base_red_r   <= cfg_pwdata[CHAN_W-1:0];
        REG_BASE_GREEN: base_green_r <= cfg_pwdata[CHAN_W-1:0];
        REG_BASE_BLUE:  base_blue_r  <= cfg_pwdata[CHAN_W-1:0];
        REG_FLOOR:      floor_r      <= cfg_pwdata[CHAN_W-1:0];
        REG_CEILING:    ceiling_r    <= cfg_pwdata[CHAN_W-1:0];
        REG_PERIOD:     period_r     <= cfg_pwdata[PERIOD_W-1:0];
        REG_INTERVAL:   interval_r   <= cfg_pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BASE_RED:   cfg_prdata = APB_DW'(base_red_r);
      REG_BASE_GREEN: cfg_prdata = APB_DW'(base_green_r);
      REG_BASE_BLUE:  cfg_prdata = APB_DW'(base_blue_r);
      REG_FLOOR:      cfg_prdata = APB_DW'(floor_r);
      REG_CEILING:    cfg_prdata = APB_DW'(ceiling_r);
      REG_PERIOD:     cfg_prdata = APB_DW'(period_r);
      REG_INTERVAL:   cfg_prdata = APB_DW'(interval_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Effective settings: a zero period acts as one, a low ceiling as the floor.
  // ---------------------------------------------------------------------
  logic [PERIOD_W-1:0] per_eff;
  logic [CHAN_W-1:0]   ceil_eff;
  logic [CHAN_W-1:0]   span;

  assign per_eff  = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign ceil_eff = (ceiling_r < floor_r) ? floor_r : ceiling_r;
  assign span     = ceil_eff - floor_r;

  // Output register is free when it is empty or being emptied this cycle.
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------------
  // Input transfer and the elapsed-time check. A finished result that cannot
  // move to the output register yet keeps the input closed.
  // ---------------------------------------------------------------------
  logic             in_acc;
  logic [NOW_W-1:0] elapsed;
  logic             upd;

  assign in_tready = (state_r == S_IDLE) && (!pend_r || out_free);
  assign in_acc    = in_tvalid && in_tready;
  assign elapsed   = in_tdata - last_r;
  assign upd       = (elapsed >= NOW_W'(interval_r));

  // ---------------------------------------------------------------------
  // Shared restoring divider step. In the modulo pass the next dividend bit
  // comes from the shift register; in the angle pass zeros are shifted in,
  // which divides phase * 2^ANGLE_BITS by the period.
  // ---------------------------------------------------------------------
  logic                trial_bit;
  logic [PERIOD_W:0]   trial;
  logic                trial_ge;
  logic [PERIOD_W-1:0] rem_step;

  assign trial_bit = (state_r == S_MOD) ? dvd_r[NOW_W-1] : 1'b0;
  assign trial     = {rem_r, trial_bit};
  assign trial_ge  = (trial >= {1'b0, per_eff});
  assign rem_step  = trial_ge ? PERIOD_W'(trial - {1'b0, per_eff}) : trial[PERIOD_W-1:0];

  // ---------------------------------------------------------------------
  // Quarter-wave sine table, QUARTER + 1 entries, filled at elaboration.
  // The quadrant bits fold the angle onto it and pick the sign.
  // ---------------------------------------------------------------------
  logic [SINE_FRAC_BITS-1:0] qtab [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
    assign qtab[g] = SINE_FRAC_BITS'(quarter_sine(longint'(g), ANGLE_BITS, SINE_FRAC_BITS));
  end

  logic [IDX_W-1:0] r_low;
  logic [IDX_W-1:0] qidx;

  assign r_low = {1'b0, quo_r[ANGLE_BITS-3:0]};
  assign qidx  = quo_r[ANGLE_BITS-2] ? (IDX_W'(QUARTER) - r_low) : r_low;

  // Half-lift: (sin + 1) / 2 in Q0.16.
  logic [LIFT_W-1:0]        lift;
  logic [LIFT_W+U_W-1:0]    lift_wide;
  logic [U_W-1:0]           u_val;

  assign lift      = neg_r ? ((LIFT_W'(1) << SINE_FRAC_BITS) - {1'b0, mag_r})
                           : ((LIFT_W'(1) << SINE_FRAC_BITS) + {1'b0, mag_r});
  assign lift_wide = {lift, {U_W{1'b0}}} >> LIFT_W;
  assign u_val     = lift_wide[U_W-1:0];

  // Brightness multiply.
  logic [PROD_W-1:0] lvl_prod;
  assign lvl_prod = u_r * span;

  // Shared channel multiplier with the divide by 255 done as
  // (x + (x >> 8) + 1) >> 8, exact for every product of two bytes.
  logic [CHAN_W-1:0]  ch_base;
  logic [CPROD_W-1:0] ch_prod;
  logic [CPROD_W:0]   ch_sum;
  logic [CHAN_W-1:0]  ch_val;

  always_comb begin
    case (ch_r)
      CH_RED:   ch_base = base_red_r;
      CH_GREEN: ch_base = base_green_r;
      default:  ch_base = base_blue_r;
    endcase
  end

  assign ch_prod = ch_base * level_r;
  assign ch_sum  = {1'b0, ch_prod} + (CPROD_W+1)'(ch_prod >> CHAN_W) + (CPROD_W+1)'(1);
  assign ch_val  = ch_sum[CPROD_W-1:CHAN_W];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && upd) state_nxt = S_MOD;
      S_MOD:   if (cnt_r == '0) state_nxt = S_ANG;
      S_ANG:   if (cnt_r == '0) state_nxt = S_LUT;
      S_LUT:   state_nxt = S_LIFT;
      S_LIFT:  state_nxt = S_LEVEL;
      S_LEVEL: state_nxt = S_CHAN;
      S_CHAN:  if (ch_r == CH_BLUE) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // A finished result that cannot move to the output yet holds the block.
    if (pend_r && !out_free) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      cnt_r       <= '0;
      ch_r        <= CH_RED;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pend_r && out_free) begin
        pend_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && upd) begin
            last_r <= in_tdata;
            cnt_r  <= CNT_W'(NOW_W - 1);
          end
        end
        S_MOD: begin
          cnt_r <= (cnt_r == '0) ? CNT_W'(ANGLE_BITS - 1) : cnt_r - CNT_W'(1);
        end
        S_ANG: begin
          if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
        end
        S_LEVEL: ch_r <= CH_RED;
        S_CHAN: begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == CH_BLUE) pend_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // A pending result only exists while the sequencer is idle, and in_tready
  // stays low as long as it cannot be handed to the output register, so the
  // datapath registers are never overwritten before the hand-over.

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        dvd_r <= in_tdata;
        rem_r <= '0;
        quo_r <= '0;
      end
      S_MOD: begin
        dvd_r <= {dvd_r[NOW_W-2:0], 1'b0};
        rem_r <= rem_step;
      end
      S_ANG: begin
        rem_r <= rem_step;
        quo_r <= {quo_r[ANGLE_BITS-2:0], trial_ge};
      end
      S_LUT: begin
        mag_r <= qtab[qidx];
        neg_r <= quo_r[ANGLE_BITS-1];
      end
      S_LIFT:  u_r <= u_val;
      S_LEVEL: level_r <= floor_r + lvl_prod[PROD_W-1:U_W];
      S_CHAN: begin
        case (ch_r)
          CH_RED:   red_r   <= ch_val;
          CH_GREEN: green_r <= ch_val;
          default:  blue_r  <= ch_val;
        endcase
      end
      default: ;
    endcase
    if (pend_r && out_free) out_data_r <= {level_r, blue_r, green_r, red_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_upd_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && upd && !(pend_r && !out_free)) |=> (state_r == S_MOD))
    else $error("accepted update did not start the divider");

  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_ANG) |-> (rem_r < per_eff))
    else $error("divider remainder reached the period");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHAN) |-> (level_r >= floor_r && level_r <= ceil_eff))
    else $error("brightness outside floor and ceiling");

  a_valid_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("output valid raised without a finished result");

endmodule
